// File: rtl/core/assert_macros.svh
// Assertion macros shared by the flood fill RTL.
// Each macro expects clk_i and rst_ni in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bff_pkg.sv
// Package for the bounded flood fill block: field widths, codes, state
// encoding and the command/status structs between controller and datapath.
package bff_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned PIX_W = 32;
  localparam int unsigned DIM_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Default storage sizes.
  localparam int unsigned MAX_WIDTH_DEF   = 64;
  localparam int unsigned MAX_HEIGHT_DEF  = 64;
  localparam int unsigned STACK_DEPTH_DEF = 16384;

  // Reset value of both size registers.
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Operation codes; the fourth code does nothing.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FILL  = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SEED_WAIT,
    ST_POP,
    ST_LOAD,
    ST_TEST,
    ST_PUSH,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic cv_write_item;
    logic cv_read_item;
    logic cv_read_stack;
    logic cv_write_cur;
    logic capture_read;
    logic latch_target;
    logic push_seed;
    logic set_fill;
    logic pop;
    logic load_mask;
    logic push_next;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic in_canvas;
    logic fill_ok;
    logic seed_same;
    logic clr_done;
    logic stack_empty;
    logic match;
    logic mask_zero;
    logic mask_last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/bff_ram.sv
// Generic single-clock RAM: one write port and one read port, registered read.
// Stands alone; used for the canvas and the coordinate stack.
module bff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the word holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bff_datapath.sv
// Datapath of the flood fill block: item and size registers, canvas and stack
// memories, stack pointer, neighbor mask and result registers. Uses bff_pkg, bff_ram.
`include "assert_macros.svh"

module bff_datapath #(
  parameter int unsigned MAX_WIDTH   = bff_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = bff_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned STACK_DEPTH = bff_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bff_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic [bff_pkg::OP_W-1:0]      operation_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_x_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_y_i,
  input  logic [bff_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic [bff_pkg::POS_W-1:0]     region_left_i,
  input  logic [bff_pkg::POS_W-1:0]     region_top_i,
  input  logic [bff_pkg::POS_W-1:0]     region_right_i,
  input  logic [bff_pkg::POS_W-1:0]     region_bottom_i,
  input  bff_pkg::cmd_t                 cmd_i,
  output bff_pkg::status_t              status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bff_pkg::PIX_W-1:0]     read_value_o,
  output logic                          fill_started_o
);

  import bff_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SAW   = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CRD_W = 2 * POS_W;

  // Neighbor mask bit positions, in push order.
  localparam int unsigned NB_RIGHT = 0;
  localparam int unsigned NB_LEFT  = 1;
  localparam int unsigned NB_DOWN  = 2;
  localparam int unsigned NB_UP    = 3;

  // Control registers.
  logic [DIM_W-1:0] cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] x_q, y_q, l_q, t_q, r_q, b_q;
  logic [PIX_W-1:0] pix_q;
  logic [POS_W-1:0] cur_x_q, cur_y_q;
  logic [PIX_W-1:0] target_q;
  logic [3:0]       mask_q, mask_d;
  logic [PIX_W-1:0] rv_q, rv_d, out_rv_q;
  logic             fs_q, fs_d, out_fs_q;

  // Derived values.
  logic [DIM_W-1:0] act_w, act_h, w_m1, h_m1;
  logic [POS_W-1:0] r_c, b_c;
  logic             in_canvas, fill_ok;
  logic [POS_W-1:0] nb_x, nb_y;
  logic [CNT_W-1:0] cnt_dec;
  logic             can_push;

  // Memory ports.
  logic             cv_we, cv_re;
  logic [AW-1:0]    cv_waddr, cv_raddr;
  logic [PIX_W-1:0] cv_wdata, cv_rdata;
  logic             sk_we;
  logic [CRD_W-1:0] sk_wdata, sk_rdata;
  logic [POS_W-1:0] sk_x, sk_y;

  // Canvas address of a pixel: row-major over the full storage width.
  function automatic logic [AW-1:0] pix_addr(input logic [POS_W-1:0] cx,
                                             input logic [POS_W-1:0] cy);
    pix_addr = AW'(int'(cy) * MAX_WIDTH + int'(cx));
  endfunction

  // Active canvas size is the register limited to the storage size.
  always_comb begin
    act_w = (int'(cfg_w_q) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : cfg_w_q;
    act_h = (int'(cfg_h_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_h_q;
    w_m1  = act_w - DIM_W'(1);
    h_m1  = act_h - DIM_W'(1);
  end

  // Clamp the right and bottom edges of the fill rectangle to the canvas.
  assign r_c = ({1'b0, r_q} > w_m1) ? w_m1[POS_W-1:0] : r_q;
  assign b_c = ({1'b0, b_q} > h_m1) ? h_m1[POS_W-1:0] : b_q;

  assign in_canvas = ({1'b0, x_q} < act_w) && ({1'b0, y_q} < act_h);
  assign fill_ok   = (act_w != '0) && (act_h != '0) &&
                     (x_q >= l_q) && (x_q <= r_c) && (y_q >= t_q) && (y_q <= b_c);

  // Stack word split into its row and column.
  assign sk_x = sk_rdata[POS_W-1:0];
  assign sk_y = sk_rdata[CRD_W-1:POS_W];

  // Coordinate of the next neighbor still to push.
  always_comb begin
    nb_x = cur_x_q;
    nb_y = cur_y_q;
    if (mask_q[NB_RIGHT]) begin
      nb_x = cur_x_q + POS_W'(1);
    end else if (mask_q[NB_LEFT]) begin
      nb_x = cur_x_q - POS_W'(1);
    end else if (mask_q[NB_DOWN]) begin
      nb_y = cur_y_q + POS_W'(1);
    end else begin
      nb_y = cur_y_q - POS_W'(1);
    end
  end

  assign cnt_dec  = count_q - CNT_W'(1);
  assign can_push = (count_q < CNT_W'(STACK_DEPTH));

  // Canvas port selection.
  always_comb begin
    cv_we    = 1'b0;
    cv_waddr = pix_addr(x_q, y_q);
    cv_wdata = pix_q;
    if (cmd_i.clr_step) begin
      cv_we    = 1'b1;
      cv_waddr = clr_q;
      cv_wdata = '0;
    end else if (cmd_i.cv_write_item) begin
      cv_we = 1'b1;
    end else if (cmd_i.cv_write_cur) begin
      cv_we    = 1'b1;
      cv_waddr = pix_addr(cur_x_q, cur_y_q);
    end
    cv_re    = cmd_i.cv_read_item | cmd_i.cv_read_stack;
    cv_raddr = cmd_i.cv_read_stack ? pix_addr(sk_x, sk_y) : pix_addr(x_q, y_q);
  end

  bff_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .waddr_i (cv_waddr),
    .wdata_i (cv_wdata),
    .re_i    (cv_re),
    .raddr_i (cv_raddr),
    .rdata_o (cv_rdata)
  );

  // Stack pushes: the seed, or the next neighbor; dropped when full.
  assign sk_we    = (cmd_i.push_seed | cmd_i.push_next) & can_push;
  assign sk_wdata = cmd_i.push_seed ? {y_q, x_q} : {nb_y, nb_x};

  bff_ram #(
    .WIDTH (CRD_W),
    .DEPTH (STACK_DEPTH),
    .AW    (SAW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (count_q[SAW-1:0]),
    .wdata_i (sk_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (cnt_dec[SAW-1:0]),
    .rdata_o (sk_rdata)
  );

  // Next values of the control registers.
  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_w_d = cfg_data_i;
        CFG_HEIGHT: cfg_h_d = cfg_data_i;
        default:    ;
      endcase
    end

    clr_d = cmd_i.clr_step ? clr_q + AW'(1) : clr_q;

    count_d = count_q;
    if (cmd_i.pop) begin
      count_d = cnt_dec;
    end else if (sk_we) begin
      count_d = count_q + CNT_W'(1);
    end

    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= DIM_RESET;
      cfg_h_q     <= DIM_RESET;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_w_q     <= cfg_w_d;
      cfg_h_q     <= cfg_h_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result and neighbor mask updates.
  always_comb begin
    rv_d = rv_q;
    fs_d = fs_q;
    if (cmd_i.load_item) begin
      rv_d = '0;
      fs_d = 1'b0;
    end else if (cmd_i.capture_read) begin
      rv_d = cv_rdata;
    end else if (cmd_i.set_fill) begin
      fs_d = 1'b1;
    end

    mask_d = mask_q;
    if (cmd_i.load_mask) begin
      mask_d[NB_RIGHT] = cur_x_q < r_c;
      mask_d[NB_LEFT]  = cur_x_q > l_q;
      mask_d[NB_DOWN]  = cur_y_q < b_c;
      mask_d[NB_UP]    = cur_y_q > t_q;
    end else if (cmd_i.push_next) begin
      mask_d = mask_q & (mask_q - 4'd1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= operation_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      pix_q <= pixel_value_i;
      l_q   <= region_left_i;
      t_q   <= region_top_i;
      r_q   <= region_right_i;
      b_q   <= region_bottom_i;
    end
    if (cmd_i.cv_read_stack) begin
      cur_x_q <= sk_x;
      cur_y_q <= sk_y;
    end
    if (cmd_i.latch_target) begin
      target_q <= cv_rdata;
    end
    if (cmd_i.emit) begin
      out_rv_q <= rv_q;
      out_fs_q <= fs_q;
    end
    mask_q <= mask_d;
    rv_q   <= rv_d;
    fs_q   <= fs_d;
  end

  // Status back to the controller.
  always_comb begin
    status_o.op          = op_e'(op_q);
    status_o.in_canvas   = in_canvas;
    status_o.fill_ok     = fill_ok;
    status_o.seed_same   = (cv_rdata == pix_q);
    status_o.clr_done    = (clr_q == AW'(DEPTH - 1));
    status_o.stack_empty = (count_q == '0);
    status_o.match       = (cv_rdata == target_q);
    status_o.mask_zero   = (mask_q == '0);
    status_o.mask_last   = ((mask_q & (mask_q - 4'd1)) == '0);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_rv_q;
  assign fill_started_o = out_fs_q;

  `ASSERT_HOLDS(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_IMPLIES(a_pop_nonempty, cmd_i.pop, count_q != '0, "pop from an empty stack")
  `ASSERT_IMPLIES(a_seed_empty, cmd_i.push_seed, count_q == '0, "fill began on a used stack")

endmodule

// File: rtl/core/bff_ctrl.sv
// Controller of the flood fill block: clearing pass, operation sequencing and
// the pop/test/push loop of the fill. Uses bff_pkg; drives bff_datapath.
`include "assert_macros.svh"

module bff_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bff_pkg::status_t status_i,
  output bff_pkg::cmd_t    cmd_o
);

  import bff_pkg::*;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.op)
          OP_READ: state_d = status_i.in_canvas ? ST_RD_WAIT : ST_RESP;
          OP_FILL: state_d = status_i.fill_ok ? ST_SEED_WAIT : ST_RESP;
          default: state_d = ST_RESP;
        endcase
      end
      ST_RD_WAIT:   state_d = ST_RESP;
      ST_SEED_WAIT: state_d = status_i.seed_same ? ST_RESP : ST_POP;
      ST_POP:       state_d = status_i.stack_empty ? ST_RESP : ST_LOAD;
      ST_LOAD:      state_d = ST_TEST;
      ST_TEST:      state_d = status_i.match ? ST_PUSH : ST_POP;
      ST_PUSH: begin
        if (status_i.mask_last) state_d = ST_POP;
      end
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EXEC: begin
        case (status_i.op)
          OP_WRITE: cmd_o.cv_write_item = status_i.in_canvas;
          OP_READ:  cmd_o.cv_read_item  = status_i.in_canvas;
          OP_FILL:  cmd_o.cv_read_item  = status_i.fill_ok;
          default:  ;
        endcase
      end
      ST_RD_WAIT: cmd_o.capture_read = 1'b1;
      ST_SEED_WAIT: begin
        cmd_o.latch_target = 1'b1;
        cmd_o.push_seed    = !status_i.seed_same;
        cmd_o.set_fill     = !status_i.seed_same;
      end
      ST_POP:  cmd_o.pop           = !status_i.stack_empty;
      ST_LOAD: cmd_o.cv_read_stack = 1'b1;
      ST_TEST: begin
        cmd_o.cv_write_cur = status_i.match;
        cmd_o.load_mask    = status_i.match;
      end
      ST_PUSH: cmd_o.push_next = !status_i.mask_zero;
      ST_RESP: cmd_o.emit      = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IMPLIES(a_emit_free, cmd_o.emit, status_i.out_free, "result word overwritten")
  `ASSERT_IMPLIES(a_load_ready, cmd_o.load_item, in_ready_o, "word loaded while not ready")
  `ASSERT_HOLDS(a_state_known, !$isunknown(state_q), "controller state unknown")

endmodule

// File: rtl/core/bounded_flood_fill.sv
// Top level of the bounded flood fill block: a pixel canvas with write, read
// and rectangle-bounded flood fill. Uses bff_pkg, bff_ctrl and bff_datapath.
//
//   Channel  Direction  Handshake               Word
//   cfg      in         cfg_we_i                cfg_idx_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o   operation_i .. region_bottom_i
//   out      out        out_valid_o/out_ready_i read_value_o, fill_started_o
//
// After reset the canvas, MAX_WIDTH*MAX_HEIGHT pixels (4096 by default), is cleared one pixel
// a cycle with in_ready_o low; configuration writes are taken throughout.
// Each accepted word passes an execute and a response state; a read inside the canvas adds
// a read wait state, and a fill seeded inside its rectangle a seed wait state and, unless the
// seed already has the new color, pop, load and test states per popped stack entry and push
// states per recolored pixel, paced by the single canvas and stack ports; a full output register
// holds the finished word back, while the word before it waits there as the next is accepted.
module bounded_flood_fill #(
  parameter int unsigned MAX_WIDTH   = bff_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = bff_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned STACK_DEPTH = bff_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bff_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bff_pkg::OP_W-1:0]      operation_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_x_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_y_i,
  input  logic [bff_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic [bff_pkg::POS_W-1:0]     region_left_i,
  input  logic [bff_pkg::POS_W-1:0]     region_top_i,
  input  logic [bff_pkg::POS_W-1:0]     region_right_i,
  input  logic [bff_pkg::POS_W-1:0]     region_bottom_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bff_pkg::PIX_W-1:0]     read_value_o,
  output logic                          fill_started_o
);

  import bff_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  bff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  bff_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pixel_value_i   (pixel_value_i),
    .region_left_i   (region_left_i),
    .region_top_i    (region_top_i),
    .region_right_i  (region_right_i),
    .region_bottom_i (region_bottom_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .read_value_o    (read_value_o),
    .fill_started_o  (fill_started_o)
  );

endmodule

// File: bench/canvas_checker.sv
// Checker for the bounded flood fill block: keeps its own canvas model, predicts
// one output word per accepted input word and compares it with what the block returns.
// Depends on bff_pkg for field widths, operation codes and register indexes.
`timescale 1ns / 100ps

module canvas_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bff_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bff_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bff_pkg::OP_W-1:0]      operation_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_x_i,
  input  logic [bff_pkg::POS_W-1:0]     pos_y_i,
  input  logic [bff_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic [bff_pkg::POS_W-1:0]     region_left_i,
  input  logic [bff_pkg::POS_W-1:0]     region_top_i,
  input  logic [bff_pkg::POS_W-1:0]     region_right_i,
  input  logic [bff_pkg::POS_W-1:0]     region_bottom_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bff_pkg::PIX_W-1:0]     read_value_i,
  input  logic                          fill_started_i,
  output int                            fail_count_o,
  output int                            due_count_o
);

  import bff_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] read_value;
    logic             fill_started;
  } word_t;

  // Model of the canvas and of the size registers.
  logic [PIX_W-1:0]     canvas_q [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  logic [DIM_W-1:0]     width_q;
  logic [DIM_W-1:0]     height_q;
  logic [2*POS_W-1:0]   fill_stack [STACK_DEPTH_DEF];
  int unsigned          stack_count;
  word_t                due_words [$];
  int                   fails;
  int                   due_total;

  assign fail_count_o = fails;
  assign due_count_o  = due_total;

  // Sizes in use are the register values capped at the storage size.
  function automatic int unsigned active_cols();
    return (width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_q);
  endfunction

  function automatic int unsigned active_rows();
    return (height_q > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_q);
  endfunction

  // A push onto a full stack is dropped, as in the block.
  function automatic void push_coord(int unsigned cx, int unsigned cy);
    if (stack_count < STACK_DEPTH_DEF) begin
      fill_stack[stack_count] = (2*POS_W)'(cy * MAX_WIDTH_DEF + cx);
      stack_count++;
    end
  endfunction

  // Four-connected fill of the seed color inside the clamped rectangle.
  // Returns whether the seed region was recolored.
  function automatic logic flood_region(input logic [POS_W-1:0] sx,
                                        input logic [POS_W-1:0] sy,
                                        input logic [PIX_W-1:0] color,
                                        input logic [POS_W-1:0] lft,
                                        input logic [POS_W-1:0] upper,
                                        input logic [POS_W-1:0] rgt,
                                        input logic [POS_W-1:0] lower);
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       right_c;
    int unsigned       bottom_c;
    int unsigned       cx;
    int unsigned       cy;
    logic [PIX_W-1:0]  target;
    logic [2*POS_W-1:0] at;
    cols = active_cols();
    rows = active_rows();
    if (cols == 0 || rows == 0) begin
      return 1'b0;
    end
    right_c  = (rgt > cols - 1) ? cols - 1 : rgt;
    bottom_c = (lower > rows - 1) ? rows - 1 : lower;
    if (sx < lft || sx > right_c || sy < upper || sy > bottom_c) begin
      return 1'b0;
    end
    target = canvas_q[{sy, sx}];
    if (target == color) begin
      return 1'b0;
    end
    stack_count = 0;
    push_coord(sx, sy);
    while (stack_count > 0) begin
      stack_count--;
      at = fill_stack[stack_count];
      cx = at % MAX_WIDTH_DEF;
      cy = at / MAX_WIDTH_DEF;
      if (canvas_q[at] == target) begin
        canvas_q[at] = color;
        if (cx < right_c) push_coord(cx + 1, cy);
        if (cx > lft) push_coord(cx - 1, cy);
        if (cy < bottom_c) push_coord(cx, cy + 1);
        if (cy > upper) push_coord(cx, cy - 1);
      end
    end
    return 1'b1;
  endfunction

  // Applies one input word to the model and returns the word it must produce.
  function automatic word_t apply_op(input logic [OP_W-1:0]  op,
                                     input logic [POS_W-1:0] x,
                                     input logic [POS_W-1:0] y,
                                     input logic [PIX_W-1:0] pv,
                                     input logic [POS_W-1:0] lft,
                                     input logic [POS_W-1:0] upper,
                                     input logic [POS_W-1:0] rgt,
                                     input logic [POS_W-1:0] lower);
    word_t res;
    logic  in_canvas;
    res       = '0;
    in_canvas = (x < active_cols()) && (y < active_rows());
    case (op)
      OP_WRITE: begin
        if (in_canvas) canvas_q[{y, x}] = pv;
      end
      OP_READ: begin
        if (in_canvas) res.read_value = canvas_q[{y, x}];
      end
      OP_FILL: begin
        res.fill_started = flood_region(x, y, pv, lft, upper, rgt, lower);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track register writes, check returned words, then predict newly accepted ones.
  always @(posedge clk_i or negedge rst_ni) begin : track
    word_t seen;
    word_t want;
    if (!rst_ni) begin
      foreach (canvas_q[i]) canvas_q[i] = '0;
      width_q     = DIM_RESET;
      height_q    = DIM_RESET;
      stack_count = 0;
      due_words.delete();
      due_total = 0;
      fails     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q = cfg_data_i;
          CFG_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        seen = '{read_value: read_value_i, fill_started: fill_started_i};
        if (due_words.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: output word with nothing expected: read_value %h fill_started %b",
                     $realtime, seen.read_value, seen.fill_started);
          end
          fails++;
        end else begin
          want = due_words.pop_front();
          if (seen.read_value !== want.read_value ||
              seen.fill_started !== want.fill_started) begin
            if (fails < 10) begin
              $display("%0t: mismatch: expected read_value %h fill_started %b, got %h %b",
                       $realtime, want.read_value, want.fill_started,
                       seen.read_value, seen.fill_started);
            end
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        due_words.push_back(apply_op(operation_i, pos_x_i, pos_y_i, pixel_value_i,
                                     region_left_i, region_top_i, region_right_i,
                                     region_bottom_i));
      end
      due_total = due_words.size();
    end
  end

endmodule

// File: bench/bounded_flood_fill_test.sv
// Testbench top for the bounded flood fill block: clock, reset, directed and random
// input words, size register changes and the verdict. Uses bff_pkg and canvas_checker.
`timescale 1ns / 100ps

module bounded_flood_fill_test;
  import bff_pkg::*;

  // The fourth operation code has no name in the package.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [OP_W-1:0]    operation_i;
  logic [POS_W-1:0]   pos_x_i;
  logic [POS_W-1:0]   pos_y_i;
  logic [PIX_W-1:0]   pixel_value_i;
  logic [POS_W-1:0]   region_left_i;
  logic [POS_W-1:0]   region_top_i;
  logic [POS_W-1:0]   region_right_i;
  logic [POS_W-1:0]   region_bottom_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [PIX_W-1:0]   read_value_o;
  logic               fill_started_o;
  int                 fail_count;
  int                 due_count;
  bit                 calm;
  int unsigned        stall;

  // Canvas sizes used by the random phases, one wider than storage and one of zero width.
  int phase_w [PHASES] = '{8, 1, 16, 5, 127, 64, 12, 0, 2, 64};
  int phase_h [PHASES] = '{8, 1, 4, 64, 3, 64, 12, 9, 7, 1};
  logic [PIX_W-1:0] palette [4] = '{32'h0000_0000, 32'hFF00_00FF, 32'h00FF_FF00,
                                    32'h8080_8080};

  bounded_flood_fill dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pixel_value_i  (pixel_value_i),
    .region_left_i  (region_left_i),
    .region_top_i   (region_top_i),
    .region_right_i (region_right_i),
    .region_bottom_i(region_bottom_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .fill_started_o (fill_started_o)
  );

  canvas_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pixel_value_i  (pixel_value_i),
    .region_left_i  (region_left_i),
    .region_top_i   (region_top_i),
    .region_right_i (region_right_i),
    .region_bottom_i(region_bottom_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_i   (read_value_o),
    .fill_started_i (fill_started_o),
    .fail_count_o   (fail_count),
    .due_count_o    (due_count)
  );

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length in cycles: mostly none or short, a few long, none in calm phases.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side: ready drops for random stretches.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      stall = pick_gap();
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  // Presents one word, after an optional idle gap, and waits until it is taken.
  task automatic send_word(input logic [OP_W-1:0]  op,
                           input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y,
                           input logic [PIX_W-1:0] pv,
                           input logic [POS_W-1:0] lft,
                           input logic [POS_W-1:0] upper,
                           input logic [POS_W-1:0] rgt,
                           input logic [POS_W-1:0] lower);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i     <= op;
    pos_x_i         <= x;
    pos_y_i         <= y;
    pixel_value_i   <= pv;
    region_left_i   <= lft;
    region_top_i    <= upper;
    region_right_i  <= rgt;
    region_bottom_i <= lower;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
  endtask

  // Writes both size registers once the block is idle.
  task automatic set_canvas(input int cols, input int rows);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= DIM_W'(cols);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= DIM_W'(rows);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One random word shaped for the given canvas size. Rectangles stay near the
  // seed on large canvases so that fills remain short.
  task automatic random_item(input int unsigned cols, input int unsigned rows);
    int unsigned      roll;
    int unsigned      x;
    int unsigned      y;
    logic [OP_W-1:0]  op;
    logic [PIX_W-1:0] color;
    logic [POS_W-1:0] lft;
    logic [POS_W-1:0] upper;
    logic [POS_W-1:0] rgt;
    logic [POS_W-1:0] lower;
    roll = $urandom_range(0, 99);
    if (roll < 45) op = OP_WRITE;
    else if (roll < 65) op = OP_READ;
    else if (roll < 95) op = OP_FILL;
    else op = OP_UNUSED;
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                     : $urandom_range(0, (cols == 0) ? 0 : cols - 1);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                     : $urandom_range(0, (rows == 0) ? 0 : rows - 1);
    color = ($urandom_range(0, 4) == 0) ? $urandom() : palette[$urandom_range(0, 3)];
    if (cols <= 16 && rows <= 16 && $urandom_range(0, 9) < 3) begin
      lft   = POS_W'($urandom_range(0, 63));
      upper = POS_W'($urandom_range(0, 63));
      rgt   = POS_W'($urandom_range(0, 63));
      lower = POS_W'($urandom_range(0, 63));
    end else begin
      lft   = POS_W'(x - $urandom_range(0, (x < 6) ? x : 6));
      upper = POS_W'(y - $urandom_range(0, (y < 6) ? y : 6));
      rgt   = POS_W'((x + $urandom_range(0, 6) > 63) ? 63 : x + $urandom_range(0, 6));
      lower = POS_W'((y + $urandom_range(0, 6) > 63) ? 63 : y + $urandom_range(0, 6));
    end
    send_word(op, POS_W'(x), POS_W'(y), color, lft, upper, rgt, lower);
  endtask

  // Stimulus: reset, directed words, then random phases over several canvas sizes.
  initial begin
    rst_ni          = 1'b0;
    calm            = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WIDTH;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    operation_i     = OP_WRITE;
    pos_x_i         = '0;
    pos_y_i         = '0;
    pixel_value_i   = '0;
    region_left_i   = '0;
    region_top_i    = '0;
    region_right_i  = '0;
    region_bottom_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of the canvas and the cleared state after reset.
    send_word(OP_READ,  6'd0,  6'd0,  32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_WRITE, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ,  6'd63, 6'd63, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_WRITE, 6'd0,  6'd0,  32'hA5A5_5A5A, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ,  6'd0,  6'd0,  32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_WRITE, 6'd5,  6'd5,  32'h1234_5678, 6'd0, 6'd0, 6'd0, 6'd0);

    // Whole-canvas fill, then a repeat that finds the seed already recolored.
    send_word(OP_FILL, 6'd10, 6'd10, 32'h0000_00FF, 6'd0, 6'd0, 6'd63, 6'd63);
    send_word(OP_FILL, 6'd10, 6'd10, 32'h0000_00FF, 6'd0, 6'd0, 6'd63, 6'd63);
    // Seed outside the rectangle, a bounded fill, and an inverted rectangle.
    send_word(OP_FILL, 6'd2,  6'd2,  32'h00FF_0000, 6'd10, 6'd10, 6'd20, 6'd20);
    send_word(OP_FILL, 6'd20, 6'd20, 32'h00FF_0000, 6'd16, 6'd16, 6'd31, 6'd31);
    send_word(OP_FILL, 6'd40, 6'd3,  32'h0000_1111, 6'd50, 6'd0,  6'd30, 6'd63);
    // The unused operation code with every field at its maximum.
    send_word(OP_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 6'd63);
    send_word(OP_READ, 6'd20, 6'd20, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ, 6'd15, 6'd16, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ, 6'd5,  6'd5,  32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    // A fill whose region is a single pixel.
    send_word(OP_FILL, 6'd63, 6'd63, 32'h0, 6'd0, 6'd0, 6'd63, 6'd63);
    send_word(OP_READ, 6'd63, 6'd63, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);

    // Small canvas: accesses outside it and a rectangle clamped to it.
    set_canvas(3, 2);
    send_word(OP_WRITE, 6'd5, 6'd1, 32'hDEAD_BEEF, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ,  6'd5, 6'd0, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_FILL,  6'd1, 6'd0, 32'h0000_0077, 6'd0, 6'd0, 6'd63, 6'd63);
    send_word(OP_READ,  6'd2, 6'd1, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);

    // Zero width gives an empty canvas.
    set_canvas(0, 5);
    send_word(OP_READ, 6'd0, 6'd0, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_FILL, 6'd0, 6'd0, 32'h0000_0042, 6'd0, 6'd0, 6'd63, 6'd63);

    // Sizes beyond storage behave as the full canvas.
    set_canvas(127, 127);
    send_word(OP_READ, 6'd3, 6'd0, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);
    send_word(OP_READ, 6'd1, 6'd1, 32'h0, 6'd0, 6'd0, 6'd0, 6'd0);

    // Random phases; every third one runs without idle gaps.
    for (int p = 0; p < PHASES; p++) begin
      set_canvas(phase_w[p], phase_h[p]);
      calm = (p % 3 == 1);
      for (int n = 0; n < 8; n++) begin
        // Once, hold off mid-phase until everything outstanding has returned.
        if (p == 2 && n == 5) drain_results();
        random_item((phase_w[p] > 64) ? 64 : phase_w[p], (phase_h[p] > 64) ? 64 : phase_h[p]);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("bounded_flood_fill test passed");
    end else begin
      $display("bounded_flood_fill test failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #20_000_000;
    $display("bounded_flood_fill test failed");
    $finish;
  end

endmodule
